>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL in this folder.
// Assumes the including module has clk_i and the active-low reset rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, off while reset is asserted.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/core/btok_pkg.sv
// Package for the boot menu config tokenizer: sizes, record and fault codes,
// parser mode and number phase codes, keyword character tables. No dependencies.
package btok_pkg;

  // Sizes
  localparam int unsigned MaxEntries    = 16;
  localparam int unsigned NameSize      = 32;
  localparam int unsigned PathSize      = 64;
  localparam int unsigned ValueCapacity = 64;

  // Record kinds
  localparam logic [2:0] KindNameChar = 3'd0;
  localparam logic [2:0] KindPathChar = 3'd1;
  localparam logic [2:0] KindNameDone = 3'd2;
  localparam logic [2:0] KindPathDone = 3'd3;
  localparam logic [2:0] KindTimeout  = 3'd4;
  localparam logic [2:0] KindError    = 3'd5;

  // Fault codes
  localparam logic [1:0] FaultTooLong   = 2'd0;
  localparam logic [1:0] FaultNoEntry   = 2'd1;
  localparam logic [1:0] FaultTooMany   = 2'd2;

  // Parser modes
  localparam logic [1:0] ModeKey   = 2'd0;
  localparam logic [1:0] ModeValue = 2'd1;
  localparam logic [1:0] ModeName  = 2'd2;

  // Number phases
  localparam logic [1:0] PhBlanks = 2'd0;
  localparam logic [1:0] PhDigits = 2'd1;
  localparam logic [1:0] PhDone   = 2'd2;

  localparam logic [7:0] EntryNone = 8'hff;

  // Characters
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChEq    = 8'h3d;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [7:0] TimeoutLen = 8'd7;
  localparam logic [7:0] PathLen    = 8'd4;

  function automatic logic [7:0] timeout_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h54; // T
      3'd1:    c = 8'h49; // I
      3'd2:    c = 8'h4d; // M
      3'd3:    c = 8'h45; // E
      3'd4:    c = 8'h4f; // O
      3'd5:    c = 8'h55; // U
      3'd6:    c = 8'h54; // T
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] path_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h50; // P
      2'd1:    c = 8'h41; // A
      2'd2:    c = 8'h54; // T
      default: c = 8'h48; // H
    endcase
    return c;
  endfunction

  // Blanks skipped ahead of a number: space, tab, VT, FF, CR.
  function automatic logic is_blank(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0b) || (b == 8'h0c) || (b == 8'h0d);
  endfunction

endpackage

>>> rtl/core/boot_menu_config_tokenizer.sv
// Boot menu config tokenizer: byte-stream parser producing name, path and
// timeout records. Depends on btok_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one file byte per
//   transaction plus start_of_file_i, which clears the parser before that
//   byte is handled. A zero byte ends the file and halts the parser; bytes
//   are then dropped until a transaction with start_of_file_i set.
//   Output channel (out_valid_o / out_stall_i) carries at most one record per
//   input byte: name/path characters, completion records, timeout values or
//   an error, after which the parser halts as well.
//   Throughput: one byte per cycle while the receiver does not stall. A byte
//   goes into an input register; the parser state and result register take
//   it once the result register is empty or not stalled, and hold its record.
//   When the receiver stalls, the record is held in the result register and
//   one more byte waits in the input register; then in_stall_o rises.
//   Reset clears the parser to key mode with no entry and both registers empty.
`include "assert_macros.svh"

module boot_menu_config_tokenizer #(
  parameter int unsigned MaxEntries    = btok_pkg::MaxEntries,
  parameter int unsigned NameSize      = btok_pkg::NameSize,
  parameter int unsigned PathSize      = btok_pkg::PathSize,
  parameter int unsigned ValueCapacity = btok_pkg::ValueCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         in_byte_i,
  input  logic               start_of_file_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         record_kind_o,
  output logic [3:0]         entry_number_o,
  output logic [5:0]         char_position_o,
  output logic [7:0]         char_value_o,
  output logic signed [31:0] timeout_number_o,
  output logic [1:0]         fault_code_o
);

  localparam logic [5:0] NameKeep = 6'(NameSize - 1);
  localparam logic [5:0] PathKeep = 6'(PathSize - 1);
  localparam logic [5:0] CapLimit = 6'(ValueCapacity - 1);
  localparam logic [7:0] MaxEnt   = 8'(MaxEntries);

  // Input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_sof_q;

  // Result register
  logic        out_vld_q;
  logic [2:0]  kind_q, kind_d;
  logic [3:0]  entry_q, entry_d;
  logic [5:0]  pos_q, pos_d;
  logic [7:0]  char_q, char_d;
  logic [31:0] num_q, num_d;
  logic [1:0]  fault_q, fault_d;
  logic        res_vld_d;

  // Parser state
  logic [1:0]  mode_q, mode_d;
  logic        skip_q, skip_d;
  logic [7:0]  klen_q, klen_d;
  logic        kwrap_q, kwrap_d;
  logic        tok_q, tok_d;
  logic        pok_q, pok_d;
  logic        visp_q, visp_d;
  logic [5:0]  vcnt_q, vcnt_d;
  logic [7:0]  cur_entry_q, cur_entry_d;
  logic [1:0]  phase_q, phase_d;
  logic        neg_q, neg_d;
  logic [31:0] acc_q, acc_d;
  logic        halted_q, halted_d;

  logic in_accept, proc_go, fire;

  assign proc_go   = !out_vld_q || !out_stall_i;
  assign fire      = in_vld_q && proc_go;
  assign in_stall_o = in_vld_q && !proc_go;
  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    logic [1:0]  c_mode;
    logic        c_skip;
    logic [7:0]  c_klen;
    logic        c_kwrap;
    logic        c_tok;
    logic        c_pok;
    logic        c_visp;
    logic [5:0]  c_vcnt;
    logic [7:0]  c_entry;
    logic [1:0]  c_phase;
    logic        c_neg;
    logic [31:0] c_acc;
    logic        c_halted;
    logic [7:0]  b;
    logic [7:0]  target;
    logic        is_name;
    logic [5:0]  keep;
    logic [5:0]  kept;
    logic        digit;
    logic [31:0] acc_next;

    b = in_byte_q;
    // start of file: parse from reset values
    if (in_sof_q) begin
      c_mode = btok_pkg::ModeKey;    c_skip = 1'b0;
      c_klen = 8'd0;                 c_kwrap = 1'b0;
      c_tok = 1'b1;                  c_pok = 1'b1;
      c_visp = 1'b0;                 c_vcnt = 6'd0;
      c_entry = btok_pkg::EntryNone; c_phase = btok_pkg::PhBlanks;
      c_neg = 1'b0;                  c_acc = 32'd0;
      c_halted = 1'b0;
    end else begin
      c_mode = mode_q;       c_skip = skip_q;
      c_klen = klen_q;       c_kwrap = kwrap_q;
      c_tok = tok_q;         c_pok = pok_q;
      c_visp = visp_q;       c_vcnt = vcnt_q;
      c_entry = cur_entry_q; c_phase = phase_q;
      c_neg = neg_q;         c_acc = acc_q;
      c_halted = halted_q;
    end

    mode_d = c_mode;   skip_d = c_skip;   klen_d = c_klen;   kwrap_d = c_kwrap;
    tok_d = c_tok;     pok_d = c_pok;     visp_d = c_visp;   vcnt_d = c_vcnt;
    cur_entry_d = c_entry; phase_d = c_phase; neg_d = c_neg; acc_d = c_acc;
    halted_d = c_halted;

    res_vld_d = 1'b0;
    kind_d    = btok_pkg::KindNameChar;
    entry_d   = 4'd0;
    pos_d     = 6'd0;
    char_d    = 8'd0;
    num_d     = 32'd0;
    fault_d   = btok_pkg::FaultTooLong;

    target   = (c_entry == btok_pkg::EntryNone) ? 8'd0 : c_entry + 8'd1;
    is_name  = (c_mode == btok_pkg::ModeName);
    keep     = is_name ? NameKeep : PathKeep;
    kept     = (c_vcnt < keep) ? c_vcnt : keep;
    digit    = (b >= btok_pkg::ChZero) && (b <= btok_pkg::ChNine);
    // acc * 10 + digit, as shifts and adds
    acc_next = {c_acc[28:0], 3'b000} + {c_acc[30:0], 1'b0} + {24'd0, b - btok_pkg::ChZero};

    if (!c_halted) begin
      priority if (b == btok_pkg::ChNul) begin
        halted_d = 1'b1;
      end else if (c_skip) begin
        skip_d = 1'b0;
      end else if (c_mode == btok_pkg::ModeKey) begin
        priority if (b == btok_pkg::ChLf) begin
          klen_d = 8'd0; kwrap_d = 1'b0; tok_d = 1'b1; pok_d = 1'b1;
        end else if (b == btok_pkg::ChHash) begin
          mode_d = btok_pkg::ModeName;
          skip_d = 1'b1;
          vcnt_d = 6'd0;
        end else if (b == btok_pkg::ChEq && c_klen == btok_pkg::TimeoutLen && c_tok) begin
          mode_d  = btok_pkg::ModeValue;
          visp_d  = 1'b0;
          vcnt_d  = 6'd0;
          phase_d = btok_pkg::PhBlanks;
          neg_d   = 1'b0;
          acc_d   = 32'd0;
        end else if (b == btok_pkg::ChEq && c_klen == btok_pkg::PathLen && c_pok) begin
          mode_d = btok_pkg::ModeValue;
          visp_d = 1'b1;
          vcnt_d = 6'd0;
        end else begin
          // unmatched '=' falls through as key text
          if (!c_kwrap) begin
            if (c_klen < btok_pkg::TimeoutLen && b != btok_pkg::timeout_char(c_klen[2:0]))
              tok_d = 1'b0;
            if (c_klen < btok_pkg::PathLen && b != btok_pkg::path_char(c_klen[1:0]))
              pok_d = 1'b0;
          end
          klen_d = c_klen + 8'd1;
          if (c_klen == 8'hff) kwrap_d = 1'b1;
        end
      end else begin
        priority if (c_vcnt >= CapLimit) begin
          halted_d  = 1'b1;
          res_vld_d = 1'b1;
          kind_d    = btok_pkg::KindError;
          fault_d   = btok_pkg::FaultTooLong;
        end else if (b == btok_pkg::ChLf) begin
          mode_d = btok_pkg::ModeKey;
          vcnt_d = 6'd0;
          klen_d = 8'd0; kwrap_d = 1'b0; tok_d = 1'b1; pok_d = 1'b1;
          res_vld_d = 1'b1;
          priority if (is_name) begin
            if (target >= MaxEnt) begin
              halted_d = 1'b1;
              kind_d   = btok_pkg::KindError;
              fault_d  = btok_pkg::FaultTooMany;
            end else begin
              cur_entry_d = target;
              kind_d  = btok_pkg::KindNameDone;
              entry_d = target[3:0];
              pos_d   = kept;
            end
          end else if (c_visp) begin
            if (c_entry == btok_pkg::EntryNone) begin
              halted_d = 1'b1;
              kind_d   = btok_pkg::KindError;
              fault_d  = btok_pkg::FaultNoEntry;
            end else begin
              kind_d  = btok_pkg::KindPathDone;
              entry_d = c_entry[3:0];
              pos_d   = kept;
            end
          end else begin
            kind_d = btok_pkg::KindTimeout;
            num_d  = c_neg ? (32'd0 - c_acc) : c_acc;
          end
        end else begin
          vcnt_d = c_vcnt + 6'd1;
          priority if (is_name) begin
            if (target < MaxEnt && c_vcnt < keep) begin
              res_vld_d = 1'b1;
              kind_d    = btok_pkg::KindNameChar;
              entry_d   = target[3:0];
              pos_d     = c_vcnt;
              char_d    = b;
            end
          end else if (c_visp) begin
            if (c_entry != btok_pkg::EntryNone && c_vcnt < keep) begin
              res_vld_d = 1'b1;
              kind_d    = btok_pkg::KindPathChar;
              entry_d   = c_entry[3:0];
              pos_d     = c_vcnt;
              char_d    = b;
            end
          end else begin
            // atoi-style number feed
            if (c_phase == btok_pkg::PhBlanks) begin
              priority if (btok_pkg::is_blank(b)) begin
                phase_d = c_phase;
              end else if (b == btok_pkg::ChPlus || b == btok_pkg::ChMinus) begin
                neg_d   = (b == btok_pkg::ChMinus);
                phase_d = btok_pkg::PhDigits;
              end else if (digit) begin
                phase_d = btok_pkg::PhDigits;
                acc_d   = acc_next;
              end else begin
                phase_d = btok_pkg::PhDone;
              end
            end else if (c_phase == btok_pkg::PhDigits) begin
              if (digit) acc_d = acc_next;
              else       phase_d = btok_pkg::PhDone;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= in_byte_i;
      in_sof_q  <= start_of_file_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= btok_pkg::ModeKey;
      skip_q      <= 1'b0;
      klen_q      <= 8'd0;
      kwrap_q     <= 1'b0;
      tok_q       <= 1'b1;
      pok_q       <= 1'b1;
      visp_q      <= 1'b0;
      vcnt_q      <= 6'd0;
      cur_entry_q <= btok_pkg::EntryNone;
      phase_q     <= btok_pkg::PhBlanks;
      neg_q       <= 1'b0;
      acc_q       <= 32'd0;
      halted_q    <= 1'b0;
    end else if (fire) begin
      mode_q      <= mode_d;
      skip_q      <= skip_d;
      klen_q      <= klen_d;
      kwrap_q     <= kwrap_d;
      tok_q       <= tok_d;
      pok_q       <= pok_d;
      visp_q      <= visp_d;
      vcnt_q      <= vcnt_d;
      cur_entry_q <= cur_entry_d;
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      acc_q       <= acc_d;
      halted_q    <= halted_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc_go) begin
      out_vld_q <= fire && res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_vld_d) begin
      kind_q  <= kind_d;
      entry_q <= entry_d;
      pos_q   <= pos_d;
      char_q  <= char_d;
      num_q   <= num_d;
      fault_q <= fault_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign record_kind_o    = kind_q;
  assign entry_number_o   = entry_q;
  assign char_position_o  = pos_q;
  assign char_value_o     = char_q;
  assign timeout_number_o = $signed(num_q);
  assign fault_code_o     = fault_q;

  `ASSERT_RST(a_err_halts, fire && res_vld_d && kind_d == btok_pkg::KindError |=> halted_q,
              "error record did not halt the parser")
  `ASSERT_RST(a_halt_quiet, fire && halted_q && !in_sof_q |-> !res_vld_d,
              "halted parser produced a record")
  `ASSERT_RST(a_skip_in_name, skip_q |-> mode_q == btok_pkg::ModeName,
              "pending byte drop outside name mode")
  `ASSERT_RST(a_vcnt_bound, vcnt_q <= CapLimit, "value count beyond capacity")
  `ASSERT_RST(a_no_entry_tag,
              out_vld_q && (kind_q == btok_pkg::KindTimeout || kind_q == btok_pkg::KindError)
              |-> entry_q == 4'd0 && pos_q == 6'd0 && char_q == 8'd0,
              "timeout or error record carries entry fields")

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for boot_menu_config_tokenizer: byte streams of config
// files with random idle on both channels, records checked against a local parser.
// Depends on btok_pkg and the tokenizer RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CycleLimit  = 800000;
  localparam int unsigned RandomItems = 560;
  localparam int unsigned LongHold    = 300;

  localparam logic [55:0] KeyTimeout = "TIMEOUT";
  localparam logic [31:0] KeyPath    = "PATH";
  // space, tab, VT, FF, CR
  localparam logic [39:0] BlankSet   = 40'h20090b0c0d;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  entry;
    logic [5:0]  pos;
    logic [7:0]  ch;
    logic [31:0] num;
    logic [1:0]  fault;
  } record_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic [7:0]         in_byte_i       = 8'h00;
  logic               start_of_file_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic [2:0]         record_kind_o;
  logic [3:0]         entry_number_o;
  logic [5:0]         char_position_o;
  logic [7:0]         char_value_o;
  logic signed [31:0] timeout_number_o;
  logic [1:0]         fault_code_o;

  boot_menu_config_tokenizer dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Parser shadow state
  logic [1:0]  scan_mode;
  bit          drop_next;
  logic [7:0]  key_len;
  bit          key_wrapped;
  bit          timeout_match;
  bit          path_match;
  bit          value_path;
  int unsigned value_len;
  logic [7:0]  entry_idx;
  logic [1:0]  num_phase;
  bit          num_neg;
  logic [31:0] num_acc;
  bit          parse_halted;

  record_t     records_due[$];

  bit          file_start;
  bit          no_idle;
  bit          hold_request;
  int unsigned live_items;
  int unsigned error_count;
  int unsigned cycle_count;

  function automatic logic [7:0] keyword_char(input bit timeout_word, input int unsigned idx);
    if (timeout_word && idx < btok_pkg::TimeoutLen) return KeyTimeout[8*(6-idx) +: 8];
    if (!timeout_word && idx < btok_pkg::PathLen) return KeyPath[8*(3-idx) +: 8];
    return "X";
  endfunction

  function automatic void clear_key();
    key_len       = 8'd0;
    key_wrapped   = 1'b0;
    timeout_match = 1'b1;
    path_match    = 1'b1;
  endfunction

  function automatic void clear_parser();
    scan_mode    = btok_pkg::ModeKey;
    drop_next    = 1'b0;
    clear_key();
    value_path   = 1'b0;
    value_len    = 0;
    entry_idx    = btok_pkg::EntryNone;
    num_phase    = btok_pkg::PhBlanks;
    num_neg      = 1'b0;
    num_acc      = 32'd0;
    parse_halted = 1'b0;
  endfunction

  function automatic void push_record(input logic [2:0] kind, input int unsigned entry,
                                      input int unsigned pos, input logic [7:0] ch,
                                      input logic [31:0] num, input logic [1:0] fault);
    record_t r;
    r.kind  = kind;
    r.entry = entry[3:0];
    r.pos   = pos[5:0];
    r.ch    = ch;
    r.num   = num;
    r.fault = fault;
    records_due.push_back(r);
  endfunction

  function automatic void raise_fault(input logic [1:0] code);
    parse_halted = 1'b1;
    push_record(btok_pkg::KindError, 0, 0, 8'h00, 32'd0, code);
  endfunction

  // Updates the shadow parser with one accepted byte and queues its record, if any.
  function automatic void predict_byte(input logic [7:0] b, input logic sof);
    int unsigned target, keep, pos, kept;
    bit          is_name, digit;
    if (sof) clear_parser();
    if (parse_halted) return;
    live_items++;
    if (b == btok_pkg::ChNul) begin
      parse_halted = 1'b1;
      return;
    end
    if (drop_next) begin
      drop_next = 1'b0;
      return;
    end

    if (scan_mode == btok_pkg::ModeKey) begin
      if (b == btok_pkg::ChLf) begin
        clear_key();
      end else if (b == btok_pkg::ChHash) begin
        scan_mode = btok_pkg::ModeName;
        drop_next = 1'b1;
        value_len = 0;
      end else if (b == btok_pkg::ChEq && key_len == btok_pkg::TimeoutLen && timeout_match) begin
        scan_mode  = btok_pkg::ModeValue;
        value_path = 1'b0;
        value_len  = 0;
        num_phase  = btok_pkg::PhBlanks;
        num_neg    = 1'b0;
        num_acc    = 32'd0;
      end else if (b == btok_pkg::ChEq && key_len == btok_pkg::PathLen && path_match) begin
        scan_mode  = btok_pkg::ModeValue;
        value_path = 1'b1;
        value_len  = 0;
      end else begin
        // '=' that opens nothing falls through and counts as key text
        if (!key_wrapped) begin
          if (key_len < btok_pkg::TimeoutLen && b != keyword_char(1'b1, 32'(key_len)))
            timeout_match = 1'b0;
          if (key_len < btok_pkg::PathLen && b != keyword_char(1'b0, 32'(key_len)))
            path_match = 1'b0;
        end
        key_len = key_len + 8'd1;
        if (key_len == 8'd0) key_wrapped = 1'b1;
      end
      return;
    end

    target  = (entry_idx == btok_pkg::EntryNone) ? 0 : entry_idx + 1;
    is_name = (scan_mode == btok_pkg::ModeName);
    keep    = is_name ? btok_pkg::NameSize - 1 : btok_pkg::PathSize - 1;
    pos     = value_len;
    if (value_len >= btok_pkg::ValueCapacity - 1) begin
      raise_fault(btok_pkg::FaultTooLong);
      return;
    end

    if (b == btok_pkg::ChLf) begin
      kept      = (pos < keep) ? pos : keep;
      scan_mode = btok_pkg::ModeKey;
      value_len = 0;
      clear_key();
      if (is_name) begin
        if (target >= btok_pkg::MaxEntries) begin
          raise_fault(btok_pkg::FaultTooMany);
        end else begin
          entry_idx = target[7:0];
          push_record(btok_pkg::KindNameDone, target, kept, 8'h00, 32'd0, 2'd0);
        end
      end else if (value_path) begin
        if (entry_idx == btok_pkg::EntryNone) raise_fault(btok_pkg::FaultNoEntry);
        else push_record(btok_pkg::KindPathDone, 32'(entry_idx), kept, 8'h00, 32'd0, 2'd0);
      end else begin
        push_record(btok_pkg::KindTimeout, 0, 0, 8'h00,
                    num_neg ? 32'd0 - num_acc : num_acc, 2'd0);
      end
      return;
    end

    value_len = pos + 1;
    if (is_name) begin
      if (target < btok_pkg::MaxEntries && pos < keep)
        push_record(btok_pkg::KindNameChar, target, pos, b, 32'd0, 2'd0);
    end else if (value_path) begin
      if (entry_idx != btok_pkg::EntryNone && pos < keep)
        push_record(btok_pkg::KindPathChar, 32'(entry_idx), pos, b, 32'd0, 2'd0);
    end else begin
      digit = (b >= btok_pkg::ChZero && b <= btok_pkg::ChNine);
      if (num_phase == btok_pkg::PhBlanks) begin
        if (b == 8'h20 || b == 8'h09 || b == 8'h0b || b == 8'h0c || b == 8'h0d) begin
        end else if (b == btok_pkg::ChPlus || b == btok_pkg::ChMinus) begin
          num_neg   = (b == btok_pkg::ChMinus);
          num_phase = btok_pkg::PhDigits;
        end else begin
          num_phase = digit ? btok_pkg::PhDigits : btok_pkg::PhDone;
          if (digit) num_acc = num_acc * 32'd10 + {24'd0, b - btok_pkg::ChZero};
        end
      end else if (num_phase == btok_pkg::PhDigits) begin
        if (digit) num_acc = num_acc * 32'd10 + {24'd0, b - btok_pkg::ChZero};
        else num_phase = btok_pkg::PhDone;
      end
    end
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic int unsigned pick_value_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(10);
    if (r < 93) return $urandom_range(25, 45);
    return $urandom_range(58, 66);
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == btok_pkg::ChLf);
    return b;
  endfunction

  // One input transaction; start_of_file follows file_start.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_byte_i       <= b;
    start_of_file_i <= file_start;
    do @(posedge clk_i); while (in_stall_o);
    predict_byte(b, file_start);
    file_start = 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    error_count++;
    if (error_count <= 10)
      $display("Mismatch in %s: expected 0x%0h, got 0x%0h", what, want, got);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int unsigned n;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        n = LongHold;
      end else begin
        n = idle_len();
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_records
    record_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (records_due.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("Unexpected record, kind %0d", record_kind_o);
      end else begin
        want = records_due.pop_front();
        if (record_kind_o !== want.kind)
          report_mismatch("record_kind", 32'(want.kind), 32'(record_kind_o));
        if (entry_number_o !== want.entry)
          report_mismatch("entry_number", 32'(want.entry), 32'(entry_number_o));
        if (char_position_o !== want.pos)
          report_mismatch("char_position", 32'(want.pos), 32'(char_position_o));
        if (char_value_o !== want.ch)
          report_mismatch("char_value", 32'(want.ch), 32'(char_value_o));
        if (timeout_number_o !== want.num)
          report_mismatch("timeout_number", want.num, timeout_number_o);
        if (fault_code_o !== want.fault)
          report_mismatch("fault_code", 32'(want.fault), 32'(fault_code_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_basic_file();
    file_start = 1'b1;
    send_byte(btok_pkg::ChHash);
    send_byte(8'hff);   // dropped after '#'
    send_byte(8'h01);
    send_byte(8'hff);
    send_byte(8'h80);
    send_byte(btok_pkg::ChLf);
    send_text("PATH=/a\n");
    send_text("TIMEOUT= ");
    send_byte(8'h0b);
    send_text("\t-45x7\n");
    send_byte(btok_pkg::ChNul);
  endtask

  task automatic test_faults();
    // path before any entry
    file_start = 1'b1;
    send_text("PATH=ab\n");
    send_byte("x");
    // end of file on the byte that '#' drops, then a bare end of file
    file_start = 1'b1;
    send_text("#");
    send_byte(btok_pkg::ChNul);
    send_text("#ab\n");
    file_start = 1'b1;
    send_byte(btok_pkg::ChNul);
    send_text("#ab\n");
    // number wrap, lone sign, unmatched '=', '=' inside the value
    file_start = 1'b1;
    send_text("TIMEOUT=+2147483648\n");
    send_text("TIMEOUT=-\n");
    send_text("K=1\n");
    send_text("TIMEOUT==5\n");
    // name runs past the value capacity
    send_text("#.n");
    repeat (63) send_byte("n");
    send_byte(btok_pkg::ChLf);
  endtask

  task automatic test_entry_limit();
    file_start = 1'b1;
    repeat (btok_pkg::MaxEntries) send_text("#-e\n");
    send_text("#-zz\n");
  endtask

  // Key length wraps at 256, only the leading bytes are compared
  task automatic test_key_wrap();
    file_start = 1'b1;
    send_text("#!k\n");
    send_text("TIMEOUT");
    repeat (256) send_byte("a");
    send_text("=12\n");
    send_text("PATH");
    repeat (256) send_byte("b");
    send_text("=q\n");
    send_text("TIMEOUX");
    repeat (256) send_byte("c");
    send_text("=9\n");
    send_byte(btok_pkg::ChNul);
  endtask

  // Receiver holds off while the sender keeps offering bytes
  task automatic test_output_hold();
    no_idle      = 1'b1;
    hold_request = 1'b1;
    file_start   = 1'b1;
    send_text("#:");
    for (int i = 0; i < 40; i++) send_byte(8'h41 + 8'(i));
    send_byte(btok_pkg::ChLf);
    send_text("PATH=/boot/x\n");
    send_byte(btok_pkg::ChNul);
    no_idle = 1'b0;
  endtask

  task automatic send_random_file();
    int unsigned lines, kind, len, mut;
    bit          crowd, use_timeout;
    crowd      = ($urandom_range(11) == 0);
    lines      = crowd ? $urandom_range(15, 18) : $urandom_range(1, 8);
    file_start = 1'b1;
    for (int i = 0; i < lines; i++) begin
      if (i > 0 && $urandom_range(39) == 0) file_start = 1'b1;
      if (crowd || (i == 0 && $urandom_range(4) != 0)) kind = 0;
      else kind = $urandom_range(9);
      case (kind)
        0, 1, 2: begin
          send_byte(btok_pkg::ChHash);
          send_byte(8'($urandom_range(1, 255)));
          len = crowd ? $urandom_range(3) : pick_value_len();
          repeat (len) send_byte(text_byte());
        end
        3, 4: begin
          send_text("PATH=");
          repeat (pick_value_len()) send_byte(text_byte());
        end
        5, 6: begin
          send_text("TIMEOUT=");
          repeat ($urandom_range(2)) send_byte(BlankSet[8*$urandom_range(4) +: 8]);
          case ($urandom_range(3))
            0:       send_byte(btok_pkg::ChPlus);
            1:       send_byte(btok_pkg::ChMinus);
            default: ;
          endcase
          repeat ($urandom_range(12)) send_byte(btok_pkg::ChZero + 8'($urandom_range(9)));
          repeat ($urandom_range(2)) send_byte(text_byte());
        end
        7, 8: repeat ($urandom_range(12)) send_byte(text_byte());
        default: begin
          // near-miss keyword: one short, exact or one long, one byte maybe changed
          use_timeout = $urandom_range(1);
          len = (use_timeout ? 7 : 4) + $urandom_range(2) - 1;
          mut = $urandom_range(len);
          for (int j = 0; j < len; j++)
            send_byte(j == mut ? text_byte() : keyword_char(use_timeout, j));
          send_byte(btok_pkg::ChEq);
          repeat ($urandom_range(4)) send_byte(text_byte());
        end
      endcase
      if ($urandom_range(19) != 0) send_byte(btok_pkg::ChLf);
    end
    if ($urandom_range(9) != 0) send_byte(btok_pkg::ChNul);
    if ($urandom_range(7) == 0) repeat ($urandom_range(1, 3)) send_byte(text_byte());
  endtask

  task automatic test_random_files();
    int unsigned first;
    first = live_items;
    while (live_items - first < RandomItems) begin
      no_idle = ($urandom_range(5) == 0);
      send_random_file();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clear_parser();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_basic_file();
    test_faults();
    test_entry_limit();
    test_key_wrap();
    test_output_hold();
    test_random_files();

    in_valid_i <= 1'b0;
    while (records_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/btok_pkg.sv
rtl/core/boot_menu_config_tokenizer.sv
tb/sv/testbench.sv
